[rtl/lcg48rd_pkg.sv]
package lcg48rd_pkg;

    localparam int STATE_W   = 48;
    localparam int SEED_W    = 32;
    localparam int RANGE_W   = 32;
    localparam int INT31_W   = 31;
    localparam int UNIFORM_W = 32;
    localparam int MUL_W     = 32;
    localparam int INT_SHIFT = 17;
    localparam int OUT_W     = 112;

    localparam logic [STATE_W-1:0] LCG_RESET = 48'hA0F7_5352_2C9B;
    localparam logic [STATE_W-1:0] LCG_ADD   = 48'h0000_0000_E61E;
    localparam logic [15:0]        SEED_LOW  = 16'h330E;

    // The multiplier 0xE588_D8CB_0001 split into 16-bit digits above the unit digit.
    localparam logic [15:0] LCG_MULT_MID = 16'hD8CB;
    localparam logic [15:0] LCG_MULT_TOP = 16'hE588;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP2,
        ST_COMMIT,
        ST_SCALE_LO,
        ST_SCALE_HI,
        ST_FINISH
    } ctrl_state_t;

    typedef enum logic [2:0] {
        DP_NOP,
        DP_START,
        DP_STEP2,
        DP_COMMIT,
        DP_SCALE_LO,
        DP_SCALE_HI,
        DP_FINISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

[rtl/lcg48rd_ctrl.sv]
module lcg48rd_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  lcg48rd_pkg::dp_status_t status,
    output lcg48rd_pkg::dp_cmd_t    cmd
);
    import lcg48rd_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd.op     = DP_NOP;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op     = DP_START;
                    state_next = ST_STEP2;
                end
            end
            ST_STEP2: begin
                cmd.op     = DP_STEP2;
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                cmd.op     = DP_COMMIT;
                state_next = ST_SCALE_LO;
            end
            ST_SCALE_LO: begin
                cmd.op     = DP_SCALE_LO;
                state_next = ST_SCALE_HI;
            end
            ST_SCALE_HI: begin
                cmd.op     = DP_SCALE_HI;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                // Hold here until the output register can take the item.
                if (status.out_free) begin
                    cmd.op     = DP_FINISH;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/lcg48rd_dpath.sv]
module lcg48rd_dpath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  lcg48rd_pkg::dp_cmd_t                 cmd,
    output lcg48rd_pkg::dp_status_t              status,
    input  logic                                seed_we,
    input  logic [lcg48rd_pkg::SEED_W-1:0]      seed_word,
    input  logic [lcg48rd_pkg::RANGE_W-1:0]     range_in,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lcg48rd_pkg::OUT_W-1:0]       m_tdata
);
    import lcg48rd_pkg::*;

    logic [STATE_W-1:0]   gen_state_reg, gen_state_next;
    logic [STATE_W-1:0]   acc_reg, acc_next;
    logic [2*MUL_W-1:0]   prod_reg;
    logic [RANGE_W-1:0]   range_reg;
    logic [MUL_W-1:0]     t_reg;
    logic [MUL_W-1:0]     mul_a, mul_b;
    logic                 prod_en;
    logic [STATE_W:0]     scale_sum;

    logic                 m_tvalid_reg;
    logic [STATE_W-1:0]   raw_reg;
    logic [UNIFORM_W-1:0] uniform_reg;
    logic                 chance_reg;

    // Shared 32x32 multiplier: state-update digits first, then the range scaling.
    always_comb begin
        mul_a          = '0;
        mul_b          = '0;
        prod_en        = 1'b0;
        acc_next       = acc_reg;
        gen_state_next = gen_state_reg;
        case (cmd.op)
            DP_START: begin
                mul_a    = {16'h0, LCG_MULT_MID};
                mul_b    = gen_state_reg[31:0];
                prod_en  = 1'b1;
                acc_next = gen_state_reg + LCG_ADD;
            end
            DP_STEP2: begin
                mul_a    = {16'h0, LCG_MULT_TOP};
                mul_b    = {16'h0, gen_state_reg[15:0]};
                prod_en  = 1'b1;
                acc_next = acc_reg + {prod_reg[31:0], 16'h0};
            end
            DP_COMMIT: begin
                gen_state_next = acc_reg + {prod_reg[15:0], 32'h0};
            end
            DP_SCALE_LO: begin
                mul_a   = gen_state_reg[31:0];
                mul_b   = range_reg;
                prod_en = 1'b1;
            end
            DP_SCALE_HI: begin
                mul_a   = {16'h0, gen_state_reg[47:32]};
                mul_b   = range_reg;
                prod_en = 1'b1;
            end
            default: begin
            end
        endcase
        if (seed_we) begin
            gen_state_next = {seed_word, SEED_LOW};
        end
    end

    assign scale_sum = {17'h0, t_reg} + {1'b0, prod_reg[STATE_W-1:0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gen_state_reg <= LCG_RESET;
        end else begin
            gen_state_reg <= gen_state_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        if (prod_en) begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.op == DP_START) begin
            range_reg <= range_in;
        end
        if (cmd.op == DP_SCALE_HI) begin
            t_reg <= prod_reg[63:32];
        end
        if (cmd.op == DP_FINISH) begin
            raw_reg     <= gen_state_reg;
            uniform_reg <= scale_sum[47:16];
            chance_reg  <= (range_reg != '0) && (scale_sum[47:16] == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.op == DP_FINISH) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign status.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid        = m_tvalid_reg;
    assign m_tdata         = {chance_reg, uniform_reg, raw_reg[STATE_W-1:INT_SHIFT], raw_reg};

    a_finish_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == DP_FINISH) |-> (!m_tvalid_reg || m_tready))
        else $error("result written while the output register is still held");

    a_finish_shows_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == DP_FINISH) |=> m_tvalid_reg)
        else $error("finished draw did not reach the output");

    a_chance_means_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> !(chance_reg && (uniform_reg != '0)))
        else $error("chance flag set with a nonzero uniform value");

    a_scale_below_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == DP_FINISH) |-> ((range_reg == '0 && scale_sum[47:16] == '0)
                                   || (scale_sum[47:16] < range_reg)))
        else $error("uniform value not below range");

endmodule

[rtl/lcg48_random_draw.sv]
// 48-bit linear congruential random generator with the multiplier 0xE588D8CB0001 and
// the addend 0xE61E. After reset the state is 0xA0F753522C9B; a write on the cfg port
// reloads it as the seed shifted left by 16 with 0x330E in the low bits. Each input item
// carries a range and yields one result item: the new raw 48-bit state, that state
// shifted right by 17, the uniform value floor(raw * range / 2^48) taken exactly in 0.48
// fixed point, and a chance flag that is set when range is nonzero and the uniform value
// is zero. Each accepted item passes through the states STEP2, COMMIT, SCALE_LO, SCALE_HI
// and FINISH, where its result is loaded into the output register once that register is
// free, and no new item is accepted before then: a single shared 32x32 multiplier first
// steps through the 16-bit digits of the state update and then through the two halves of
// the range scaling. The output register lets the next item be accepted while a result
// still waits to be taken. Seed writes are meant for times when no item is in flight.
module lcg48_random_draw (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input items. s_tdata: range [31:0].
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [lcg48rd_pkg::RANGE_W-1:0]     s_tdata,
    // Result items. m_tdata: raw_value [47:0], int31_value [78:48],
    // uniform_value [110:79], chance_hit [111].
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lcg48rd_pkg::OUT_W-1:0]       m_tdata,
    // Seed register write. cfg_data: seed_word [31:0].
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lcg48rd_pkg::SEED_W-1:0]      cfg_data
);
    import lcg48rd_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // The seed register is always ready; a write lands in the state register at the next clock edge.
    assign cfg_ready = 1'b1;

    lcg48rd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lcg48rd_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .seed_we   (cfg_valid && cfg_ready),
        .seed_word (cfg_data),
        .range_in  (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
